### rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants for the infix-to-postfix converter: token and
// result codes, operator stack entry layout and stack cell control.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    localparam int CMD_W  = 3;
    localparam int ID_W   = 8;
    localparam int PREC_W = 4;
    localparam int KIND_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPERAND  = 3'd0,
        CMD_FUNC     = 3'd1,
        CMD_OPERATOR = 3'd2,
        CMD_LPAREN   = 3'd3,
        CMD_RPAREN   = 3'd4,
        CMD_COMMA    = 3'd5,
        CMD_END      = 3'd6
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        OUT_OPERAND  = 3'd0,
        OUT_FUNC     = 3'd1,
        OUT_OPERATOR = 3'd2,
        OUT_END      = 3'd3,
        OUT_ERROR    = 3'd4
    } out_kind_t;

    typedef enum logic [1:0] {
        ENT_FUNC  = 2'd0,
        ENT_OP    = 2'd1,
        ENT_PAREN = 2'd2
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t          kind;
        logic [ID_W-1:0]    id;
        logic [PREC_W-1:0]  prec;
    } entry_t;

    typedef enum logic [1:0] {
        SOP_HOLD = 2'd0,
        SOP_PUSH = 2'd1,
        SOP_POP  = 2'd2
    } stack_op_t;

    typedef struct packed {
        stack_op_t op;
        logic      clear;
        entry_t    push_entry;
    } stack_ctrl_t;

    typedef struct packed {
        entry_t top;
        logic   empty;
        logic   full;
    } stack_stat_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WORK = 1'b1
    } state_t;

endpackage

### rtl/core/itp_stack_cell.sv
// ----------------------------------------------------------------------------
// itp_stack_cell
// One slot of the shifting operator stack. On a push it takes the entry of
// the slot above, on a pop the entry of the slot below.
// ----------------------------------------------------------------------------
module itp_stack_cell (
    input  logic                clk,
    input  itp_pkg::stack_op_t  op,
    input  itp_pkg::entry_t     above,
    input  itp_pkg::entry_t     below,
    output itp_pkg::entry_t     q
);
    import itp_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (op)
            SOP_PUSH: entry_next = above;
            SOP_POP:  entry_next = below;
            default:  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### rtl/core/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack built as a row of shifting cells; cell 0 is always the top.
// Keeps the fill count and reports top entry, empty and full.
// ----------------------------------------------------------------------------
module itp_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itp_pkg::stack_ctrl_t ctrl,
    output itp_pkg::stack_stat_t stat
);
    import itp_pkg::*;

    entry_t cell_q [STACK_DEPTH];

    logic [STACK_CNT_W-1:0] count_reg;
    logic [STACK_CNT_W-1:0] count_next;

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            entry_t above;
            entry_t below;

            if (i == 0)
            begin : g_top
                assign above = ctrl.push_entry;
            end
            else
            begin : g_mid
                assign above = cell_q[i-1];
            end

            // bottom slot refills with itself, it lies beyond the count after a pop
            if (i == STACK_DEPTH - 1)
            begin : g_bot
                assign below = cell_q[i];
            end
            else
            begin : g_up
                assign below = cell_q[i+1];
            end

            itp_stack_cell u_cell (
                .clk   (clk),
                .op    (ctrl.op),
                .above (above),
                .below (below),
                .q     (cell_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else
        begin
            case (ctrl.op)
                SOP_PUSH: count_next = count_reg + STACK_CNT_W'(1);
                SOP_POP:  count_next = count_reg - STACK_CNT_W'(1);
                default:  count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.top   = cell_q[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == STACK_CNT_W'(STACK_DEPTH));

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= STACK_CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == SOP_PUSH |-> !stat.full)
        else $error("push onto full stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == SOP_POP |-> !stat.empty)
        else $error("pop from empty stack");
`endif

endmodule

### rtl/core/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: classified infix tokens in, postfix tokens out.
// ----------------------------------------------------------------------------
// Usage
//   Token channel: command, token_id, op_precedence, op_right_assoc with
//   token_valid / token_stall. A request is taken when valid is high and
//   stall is low. Tokens are handled one at a time.
//   Result channel: out_kind, out_id, last with result_valid / result_stall;
//   last marks the final result a token causes. A token that causes no
//   result (push, dropped after an error) produces nothing.
//   Flow: the stack pops one entry a cycle unless the result buffer is
//   full and the output register stalled. A right paren pops operators
//   down to its paren, drops the paren, then pops a function waiting behind
//   it. An end token that meets an unmatched paren yields an error, then
//   the end marker. The next token is taken while the final result of the
//   previous one moves to the output register.
//   Stall: a held result_stall freezes the output register; work carries on
//   until the one-deep result buffer is also full, then the block waits.
//   Reset: asynchronous, active low; stack empties, error flag clears and
//   result_valid drops. Stack contents need no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          token_valid,
    output logic                          token_stall,
    input  logic [itp_pkg::CMD_W-1:0]     command,
    input  logic [itp_pkg::ID_W-1:0]      token_id,
    input  logic [itp_pkg::PREC_W-1:0]    op_precedence,
    input  logic                          op_right_assoc,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [itp_pkg::KIND_W-1:0]    out_kind,
    output logic [itp_pkg::ID_W-1:0]      out_id,
    output logic                          last
);
    import itp_pkg::*;

    state_t state_reg;
    state_t state_next;

    cmd_t               cmd_reg,    cmd_next;
    logic [ID_W-1:0]    id_reg,     id_next;
    logic [PREC_W-1:0]  prec_reg,   prec_next;
    logic               rassoc_reg, rassoc_next;

    logic phase_reg,      phase_next;
    logic error_seen_reg, error_seen_next;

    logic              pend_valid_reg, pend_valid_next;
    out_kind_t         pend_kind_reg,  pend_kind_next;
    logic [ID_W-1:0]   pend_id_reg,    pend_id_next;

    logic              out_valid_reg, out_valid_next;
    out_kind_t         out_kind_reg,  out_kind_next;
    logic [ID_W-1:0]   out_id_reg,    out_id_next;
    logic              last_reg,      last_next;

    stack_ctrl_t ctrl;
    stack_stat_t stat;

    // per-cycle decision for the token in hand
    logic            produce;
    out_kind_t       res_kind;
    logic [ID_W-1:0] res_id;
    stack_op_t       sop;
    logic            clr;
    logic            fin;
    logic            phase_set;
    logic            err_set;
    logic            err_clr;
    logic            pop_hit;
    out_kind_t       pop_kind;
    entry_t          push_e;

    logic can_emit;
    logic advance;
    logic take;

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign can_emit    = !out_valid_reg || !result_stall;
    assign token_stall = !((state_reg == ST_IDLE) && (!pend_valid_reg || can_emit));
    assign take        = token_valid && !token_stall;
    assign advance     = (state_reg == ST_WORK) && !(produce && pend_valid_reg && !can_emit);

    assign pop_kind = (stat.top.kind == ENT_FUNC) ? OUT_FUNC : OUT_OPERATOR;

    // operator pops a stacked operator that binds more tightly, or as tightly when left-associative
    assign pop_hit = !stat.empty && (stat.top.kind == ENT_OP) &&
                     (rassoc_reg ? (stat.top.prec > prec_reg) : (stat.top.prec >= prec_reg));

    always_comb
    begin
        produce   = 1'b0;
        res_kind  = OUT_ERROR;
        res_id    = '0;
        sop       = SOP_HOLD;
        clr       = 1'b0;
        fin       = 1'b0;
        phase_set = 1'b0;
        err_set   = 1'b0;
        err_clr   = 1'b0;

        push_e.id   = id_reg;
        push_e.prec = prec_reg;
        case (cmd_reg)
            CMD_FUNC:     push_e.kind = ENT_FUNC;
            CMD_OPERATOR: push_e.kind = ENT_OP;
            default:      push_e.kind = ENT_PAREN;
        endcase

        if (error_seen_reg && (cmd_reg != CMD_END))
        begin
            fin = 1'b1;
        end
        else
        begin
            case (cmd_reg)
                CMD_OPERAND:
                begin
                    produce  = 1'b1;
                    res_kind = OUT_OPERAND;
                    res_id   = id_reg;
                    fin      = 1'b1;
                end
                CMD_FUNC, CMD_LPAREN:
                begin
                    fin = 1'b1;
                    if (stat.full)
                    begin
                        produce = 1'b1;
                        err_set = 1'b1;
                    end
                    else
                    begin
                        sop = SOP_PUSH;
                    end
                end
                CMD_OPERATOR:
                begin
                    if (pop_hit)
                    begin
                        produce  = 1'b1;
                        res_kind = pop_kind;
                        res_id   = stat.top.id;
                        sop      = SOP_POP;
                    end
                    else if (stat.full)
                    begin
                        produce = 1'b1;
                        err_set = 1'b1;
                        fin     = 1'b1;
                    end
                    else
                    begin
                        sop = SOP_PUSH;
                        fin = 1'b1;
                    end
                end
                CMD_RPAREN:
                begin
                    if (phase_reg)
                    begin
                        // paren already dropped, a waiting function follows it out
                        fin = 1'b1;
                        if (!stat.empty && (stat.top.kind == ENT_FUNC))
                        begin
                            produce  = 1'b1;
                            res_kind = OUT_FUNC;
                            res_id   = stat.top.id;
                            sop      = SOP_POP;
                        end
                    end
                    else if (stat.empty)
                    begin
                        produce = 1'b1;
                        err_set = 1'b1;
                        fin     = 1'b1;
                    end
                    else if (stat.top.kind == ENT_PAREN)
                    begin
                        sop       = SOP_POP;
                        phase_set = 1'b1;
                    end
                    else
                    begin
                        produce  = 1'b1;
                        res_kind = pop_kind;
                        res_id   = stat.top.id;
                        sop      = SOP_POP;
                    end
                end
                CMD_COMMA:
                begin
                    if (stat.empty)
                    begin
                        produce = 1'b1;
                        err_set = 1'b1;
                        fin     = 1'b1;
                    end
                    else if (stat.top.kind == ENT_PAREN)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        produce  = 1'b1;
                        res_kind = pop_kind;
                        res_id   = stat.top.id;
                        sop      = SOP_POP;
                    end
                end
                CMD_END:
                begin
                    if (!phase_reg && !error_seen_reg && !stat.empty)
                    begin
                        produce = 1'b1;
                        if (stat.top.kind == ENT_PAREN)
                        begin
                            // unmatched left paren: error, then the end marker
                            phase_set = 1'b1;
                        end
                        else
                        begin
                            res_kind = pop_kind;
                            res_id   = stat.top.id;
                            sop      = SOP_POP;
                        end
                    end
                    else
                    begin
                        produce  = 1'b1;
                        res_kind = OUT_END;
                        clr      = 1'b1;
                        err_clr  = 1'b1;
                        fin      = 1'b1;
                    end
                end
                default:
                begin
                    produce = 1'b1;
                    err_set = 1'b1;
                    fin     = 1'b1;
                end
            endcase
        end
    end

    assign ctrl.op         = advance ? sop : SOP_HOLD;
    assign ctrl.clear      = advance && clr;
    assign ctrl.push_entry = push_e;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        prec_next       = prec_reg;
        rassoc_next     = rassoc_reg;
        phase_next      = phase_reg;
        error_seen_next = error_seen_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        last_next       = last_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // the buffered result is the final one of the previous token
                if (pend_valid_reg && can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_id_next     = pend_id_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                end
                if (take)
                begin
                    cmd_next    = cmd_t'(command);
                    id_next     = token_id;
                    prec_next   = op_precedence;
                    rassoc_next = op_right_assoc;
                    phase_next  = 1'b0;
                    state_next  = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (advance)
                begin
                    if (produce)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = pend_kind_reg;
                            out_id_next    = pend_id_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = res_kind;
                        pend_id_next    = res_id;
                    end
                    if (phase_set)
                    begin
                        phase_next = 1'b1;
                    end
                    if (err_set)
                    begin
                        error_seen_next = 1'b1;
                    end
                    else if (err_clr)
                    begin
                        error_seen_next = 1'b0;
                    end
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            error_seen_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            error_seen_reg <= error_seen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        prec_reg      <= prec_next;
        rassoc_reg    <= rassoc_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        last_reg      <= last_next;
    end

    assign result_valid = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_id       = out_id_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_kind_reg == OUT_END) |-> last)
        else $error("end marker without last");

    a_take_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == ST_WORK)
        else $error("request taken but no work started");

    a_end_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cmd_reg == CMD_END) && fin |=> !error_seen_reg)
        else $error("error flag still set after end marker");
`endif

endmodule

### tb/infix_to_postfix_converter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test
// Self-checking bench for the shunting-yard converter. A short table of
// hand-picked tokens comes first, then random expressions: clean ones, noisy
// ones and deep nests that nearly fill, fill or overflow the stack. Each accepted
// request is run through an in-bench stack model and the predicted postfix
// tokens are matched in order against the result channel, under random stalls.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_test;

    import itp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_BAD = 3'd7;
    localparam int PLAN_LEN   = 25;
    localparam int RAND_ITEMS = 350;
    localparam int CALM_TAIL  = 60;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } postfix_tok_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [PREC_W-1:0] prec;
        logic              ra;
        logic              typed;
        logic [KIND_W-1:0] xkind;
        logic [ID_W-1:0]   xid;
    } stim_row_t;

    localparam stim_row_t PLAN [PLAN_LEN] = '{
        '{CMD_FUNC,     8'hA5, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_LPAREN,   8'h3C, 4'h9, 1'b1, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h00, 4'hF, 1'b1, 1'b1, OUT_OPERAND,  8'h00},
        '{CMD_OPERATOR, 8'h2B, 4'h4, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'hFF, 4'h0, 1'b0, 1'b1, OUT_OPERAND,  8'hFF},
        '{CMD_COMMA,    8'h00, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h12, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_RPAREN,   8'h00, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERATOR, 8'h5E, 4'hF, 1'b1, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h13, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERATOR, 8'h5E, 4'hF, 1'b1, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_LPAREN,   8'h00, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h14, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERATOR, 8'h2D, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h15, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERATOR, 8'h2B, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_OPERAND,  8'h16, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_END,      8'h00, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_RPAREN,   8'h00, 4'h0, 1'b0, 1'b1, OUT_ERROR,    8'h00},
        '{CMD_OPERAND,  8'h77, 4'h0, 1'b0, 1'b0, OUT_OPERAND,  8'h00},
        '{CMD_END,      8'h00, 4'h0, 1'b0, 1'b1, OUT_END,      8'h00},
        '{CMD_COMMA,    8'h00, 4'h0, 1'b0, 1'b1, OUT_ERROR,    8'h00},
        '{CMD_END,      8'h00, 4'h0, 1'b0, 1'b1, OUT_END,      8'h00},
        '{CMD_BAD,      8'hC3, 4'h5, 1'b1, 1'b1, OUT_ERROR,    8'h00},
        '{CMD_END,      8'h00, 4'h0, 1'b0, 1'b1, OUT_END,      8'h00}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 token_valid;
    logic                 token_stall;
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      token_id;
    logic [PREC_W-1:0]    op_precedence;
    logic                 op_right_assoc;
    logic                 result_valid;
    logic                 result_stall;
    logic [KIND_W-1:0]    out_kind;
    logic [ID_W-1:0]      out_id;
    logic                 last;

    // model state
    entry_t       pend_stack [STACK_DEPTH];
    int           pend_count = 0;
    bit           drop_mode = 1'b0;
    postfix_tok_t step_q[$];
    postfix_tok_t postfix_q[$];
    postfix_tok_t want;

    int  fail_count = 0;
    int  req_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    infix_to_postfix_converter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .token_valid    (token_valid),
        .token_stall    (token_stall),
        .command        (command),
        .token_id       (token_id),
        .op_precedence  (op_precedence),
        .op_right_assoc (op_right_assoc),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_kind       (out_kind),
        .out_id         (out_id),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic add_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        postfix_tok_t tok;
        tok.kind = kind;
        tok.id   = id;
        tok.last = 1'b0;
        step_q = {step_q, tok};
    endtask

    task automatic flag_error();
        add_result(OUT_ERROR, '0);
        drop_mode = 1'b1;
    endtask

    task automatic pop_out();
        entry_t e;
        e = pend_stack[pend_count-1];
        pend_count--;
        add_result((e.kind == ENT_FUNC) ? OUT_FUNC : OUT_OPERATOR, e.id);
    endtask

    task automatic push_entry(input entry_t e);
        if (pend_count >= STACK_DEPTH)
            flag_error();
        else
        begin
            pend_stack[pend_count] = e;
            pend_count++;
        end
    endtask

    task automatic pop_to_paren(output bit found);
        while (pend_count > 0 && pend_stack[pend_count-1].kind != ENT_PAREN)
            pop_out();
        found = (pend_count > 0);
    endtask

    // postfix tokens caused by one request, left in step_q
    task automatic convert_token(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                 input logic [PREC_W-1:0] prec, input logic ra);
        entry_t e;
        bit     found;
        bit     done;
        step_q.delete();
        e.kind = ENT_PAREN;
        e.id   = '0;
        e.prec = '0;
        done   = 1'b0;
        if (cmd == CMD_END)
        begin
            if (!drop_mode)
            begin
                while (!done && pend_count > 0)
                begin
                    // an open paren left behind is an error, the rest is discarded
                    if (pend_stack[pend_count-1].kind == ENT_PAREN)
                    begin
                        add_result(OUT_ERROR, '0);
                        done = 1'b1;
                    end
                    else
                        pop_out();
                end
            end
            pend_count = 0;
            drop_mode  = 1'b0;
            add_result(OUT_END, '0);
        end
        else if (!drop_mode)
        begin
            case (cmd)
                CMD_OPERAND:
                    add_result(OUT_OPERAND, id);
                CMD_FUNC:
                begin
                    e.kind = ENT_FUNC;
                    e.id   = id;
                    push_entry(e);
                end
                CMD_OPERATOR:
                begin
                    while (!done && pend_count > 0)
                    begin
                        if (pend_stack[pend_count-1].kind != ENT_OP)
                            done = 1'b1;
                        else if (ra ? (pend_stack[pend_count-1].prec > prec)
                                    : (pend_stack[pend_count-1].prec >= prec))
                            pop_out();
                        else
                            done = 1'b1;
                    end
                    e.kind = ENT_OP;
                    e.id   = id;
                    e.prec = prec;
                    push_entry(e);
                end
                CMD_LPAREN:
                    push_entry(e);
                CMD_RPAREN:
                begin
                    pop_to_paren(found);
                    if (!found)
                        flag_error();
                    else
                    begin
                        pend_count--;
                        if (pend_count > 0 && pend_stack[pend_count-1].kind == ENT_FUNC)
                            pop_out();
                    end
                end
                CMD_COMMA:
                begin
                    pop_to_paren(found);
                    if (!found)
                        flag_error();
                end
                default:
                    flag_error();
            endcase
        end
        if (step_q.size() > 0)
            step_q[step_q.size()-1].last = 1'b1;
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [PREC_W-1:0] prec, input logic ra,
                              input logic typed, input logic [KIND_W-1:0] xkind,
                              input logic [ID_W-1:0] xid);
        postfix_tok_t tok;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            token_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        token_valid    <= 1'b1;
        command        <= cmd;
        token_id       <= id;
        op_precedence  <= prec;
        op_right_assoc <= ra;
        @(posedge clk);
        while (token_stall)
            @(posedge clk);
        req_count++;
        convert_token(cmd, id, prec, ra);
        if (typed)
        begin
            tok.kind = xkind;
            tok.id   = xid;
            tok.last = 1'b1;
            postfix_q = {postfix_q, tok};
        end
        else
            foreach (step_q[i])
                postfix_q = {postfix_q, step_q[i]};
    endtask

    task automatic gen_token(input logic [CMD_W-1:0] cmd, input int prec,
                             input int ra, input bit noisy);
        logic [CMD_W-1:0]  c;
        logic [PREC_W-1:0] p;
        logic              r;
        c = cmd;
        p = PREC_W'(prec);
        r = 1'(ra);
        if (noisy && $urandom_range(0, 7) == 0)
        begin
            c = CMD_W'($urandom_range(0, 7));
            p = PREC_W'($urandom_range(0, 15));
            r = 1'($urandom_range(0, 1));
        end
        send_token(c, ID_W'($urandom_range(0, 255)), p, r, 1'b0, OUT_OPERAND, '0);
    endtask

    task automatic hold_until_drained();
        token_valid <= 1'b0;
        do
            @(posedge clk);
        while (postfix_q.size() != 0);
    endtask

    // well formed expression of roughly len_goal requests, optionally with junk mixed in
    task automatic send_expression(input int len_goal, input bit noisy);
        int   stop_at;
        int   depth;
        int   r;
        bit   want_operand;
        int   p;
        stop_at      = req_count + len_goal;
        depth        = 0;
        want_operand = 1'b1;
        while (req_count < stop_at || depth > 0 || want_operand)
        begin
            r = $urandom_range(0, 9);
            if (want_operand)
            begin
                if (r < 2 && depth < 6 && req_count < stop_at)
                begin
                    gen_token(CMD_LPAREN, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                    depth++;
                end
                else if (r < 3 && depth < 6 && req_count < stop_at)
                begin
                    gen_token(CMD_FUNC, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                    gen_token(CMD_LPAREN, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                    depth++;
                end
                else
                begin
                    gen_token(CMD_OPERAND, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                    want_operand = 1'b0;
                end
            end
            else if (depth > 0 && (req_count >= stop_at || r < 3))
            begin
                gen_token(CMD_RPAREN, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                depth--;
            end
            else if (depth > 0 && r < 4)
            begin
                gen_token(CMD_COMMA, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
                want_operand = 1'b1;
            end
            else if (req_count < stop_at)
            begin
                // narrow precedence range so equal precedences meet often
                p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 6);
                gen_token(CMD_OPERATOR, p, $urandom_range(0, 1), noisy);
                want_operand = 1'b1;
            end
        end
        gen_token(CMD_END, $urandom_range(0, 15), $urandom_range(0, 1), noisy);
    endtask

    // nest that stops one short of a full stack, fills it or goes one past it
    task automatic send_deep_nest();
        int n_push;
        int k;
        int p;
        n_push = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1);
        for (k = 0; k < n_push; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                gen_token(CMD_OPERAND, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
            case ($urandom_range(0, 2))
                0: gen_token(CMD_LPAREN, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
                1: gen_token(CMD_FUNC, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
                default:
                begin
                    // rising precedence so nothing pops, right assoc once it saturates
                    p = (k > 15) ? 15 : k;
                    gen_token(CMD_OPERATOR, p, (k >= 15) ? 1 : $urandom_range(0, 1),
                              1'b0);
                end
            endcase
        end
        gen_token(CMD_OPERAND, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
        repeat ($urandom_range(0, 3))
            gen_token(CMD_RPAREN, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
        gen_token(CMD_END, $urandom_range(0, 15), $urandom_range(0, 1), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            if (stall_left == 0)
                result_stall <= 1'b0;
        end
        else if (!quiet && rst_n && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 14);
            result_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (postfix_q.size() == 0)
            begin
                $error("unexpected result: out_kind %0d out_id %0d last %0d",
                       out_kind, out_id, last);
                fail_count++;
            end
            else
            begin
                want = postfix_q.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                    fail_count++;
                end
                if (out_id !== want.id)
                begin
                    $error("out_id: expected %0d, actual %0d", want.id, out_id);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        bit drained_once;
        bit first_pick;
        int pick;
        drained_once   = 1'b0;
        first_pick     = 1'b1;
        rst_n          = 1'b0;
        token_valid    = 1'b0;
        command        = '0;
        token_id       = '0;
        op_precedence  = '0;
        op_right_assoc = 1'b0;
        result_stall   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
            send_token(PLAN[i].cmd, PLAN[i].id, PLAN[i].prec, PLAN[i].ra,
                       PLAN[i].typed, PLAN[i].xkind, PLAN[i].xid);

        while (req_count < PLAN_LEN + RAND_ITEMS)
        begin
            if (req_count >= PLAN_LEN + RAND_ITEMS - CALM_TAIL)
                quiet = 1'b1;
            pick = first_pick ? 0 : $urandom_range(0, 9);
            first_pick = 1'b0;
            if (pick == 0)
                send_deep_nest();
            else
                send_expression($urandom_range(3, 20), pick < 3);
            if ((!drained_once && req_count >= PLAN_LEN + RAND_ITEMS / 2)
                || (!quiet && $urandom_range(0, 11) == 0))
            begin
                hold_until_drained();
                drained_once = 1'b1;
            end
        end

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && postfix_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/itp_pkg.sv
rtl/core/itp_stack_cell.sv
rtl/core/itp_stack.sv
rtl/core/infix_to_postfix_converter_unit.sv
tb/infix_to_postfix_converter_unit_test.sv
